### hw/rtl/gpalu_pkg.sv
package gpalu_pkg;

  // Width of the packed polynomial inside the datapath, and of the ports.
  localparam int PolyWidth = 64;
  localparam int DataW     = 64;
  localparam int CntW      = (PolyWidth > 1) ? $clog2(PolyWidth) : 1;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_MUL = 2'd1,
    MODE_QUO = 2'd2,
    MODE_REM = 2'd3
  } mode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } gpalu_cmd_t;

endpackage

### hw/rtl/gpalu_ctrl.sv
module gpalu_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             mode_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output gpalu_pkg::gpalu_cmd_t  cmd_o
);
  import gpalu_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic            out_valid_q;
  logic            accept;
  logic            slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  assign cmd_o.load   = accept;
  assign cmd_o.step   = (state_q == ST_RUN);
  assign cmd_o.finish = (state_q == ST_HOLD) && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A new result may replace the one that leaves at this same edge.
      if (cmd_o.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cnt_q <= '0;
            // Addition is done at load time, so it skips the stepping phase.
            if (mode_e'(mode_i) == MODE_ADD) begin
              state_q <= ST_HOLD;
            end else begin
              state_q <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (cnt_q == CntW'(PolyWidth - 1)) begin
            state_q <= ST_HOLD;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_HOLD: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/gpalu_dp.sv
module gpalu_dp (
  input  logic                         clk_i,
  input  gpalu_pkg::gpalu_cmd_t        cmd_i,
  input  logic [1:0]                   mode_i,
  input  logic [gpalu_pkg::DataW-1:0]  operand_a_i,
  input  logic [gpalu_pkg::DataW-1:0]  operand_b_i,
  output logic [gpalu_pkg::DataW-1:0]  result_o,
  output logic                         divide_by_zero_o
);
  import gpalu_pkg::*;

  typedef logic [PolyWidth-1:0] poly_t;

  // One-hot mask of the leading coefficient; zero for the zero polynomial.
  function automatic poly_t lead_bit(input poly_t v);
    poly_t s;
    s = v;
    for (int k = 1; k < PolyWidth; k = k * 2) begin
      s = s | (s >> k);
    end
    return s & ~(s >> 1);
  endfunction

  poly_t x_q, x_d;
  poly_t y_q, y_d;
  poly_t acc_q, acc_d;
  poly_t quo_q, quo_d;
  poly_t lead_q, lead_d;
  poly_t res_q, res_d;
  mode_e mode_q, mode_d;
  logic  dz_q, dz_d;
  poly_t a_in, b_in;
  poly_t rem_sh;
  logic  sub;

  assign a_in = operand_a_i[PolyWidth-1:0];
  assign b_in = operand_b_i[PolyWidth-1:0];

  // Division brings in one dividend bit per step; the partial remainder never
  // exceeds the divisor's degree, so testing its leading bit decides the step.
  assign rem_sh = {acc_q[PolyWidth-2:0], x_q[PolyWidth-1]};
  assign sub    = |(rem_sh & lead_q);

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    quo_d  = quo_q;
    lead_d = lead_q;
    mode_d = mode_q;
    res_d  = res_q;
    dz_d   = dz_q;
    if (cmd_i.load) begin
      mode_d = mode_e'(mode_i);
      x_d    = a_in;
      y_d    = b_in;
      lead_d = lead_bit(b_in);
      quo_d  = '0;
      acc_d  = (mode_e'(mode_i) == MODE_ADD) ? (a_in ^ b_in) : '0;
    end else if (cmd_i.step) begin
      case (mode_q)
        MODE_MUL: begin
          if (y_q[0]) begin
            acc_d = acc_q ^ x_q;
          end
          x_d = x_q << 1;
          y_d = y_q >> 1;
        end
        MODE_QUO, MODE_REM: begin
          acc_d = sub ? (rem_sh ^ y_q) : rem_sh;
          quo_d = {quo_q[PolyWidth-2:0], sub};
          x_d   = x_q << 1;
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.finish) begin
      res_d = (mode_q == MODE_QUO) ? quo_q : acc_q;
      dz_d  = (mode_q inside {MODE_QUO, MODE_REM}) && (y_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    acc_q  <= acc_d;
    quo_q  <= quo_d;
    lead_q <= lead_d;
    mode_q <= mode_d;
    res_q  <= res_d;
    dz_q   <= dz_d;
  end

  assign result_o         = DataW'(res_q);
  assign divide_by_zero_o = dz_q;

endmodule

### hw/rtl/gf2_polynomial_alu_top.sv
// Channel   Handshake                  Beat contents
// input     in_valid_i / in_ready_o    mode_i, operand_a_i, operand_b_i
// output    out_valid_o / out_ready_i  result_o, divide_by_zero_o
//
// Multiply, quotient and remainder load the operands, run 64 steps of the
// shared shift-and-xor unit and then store the result; addition is done at
// load and goes straight to the store. One item is in work at a time, but a new beat
// is accepted while the previous result waits in the output register.
// Reset clears the controller only; a stalled output holds the unit at its end.
module gf2_polynomial_alu_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   mode_i,
  input  logic [gpalu_pkg::DataW-1:0]  operand_a_i,
  input  logic [gpalu_pkg::DataW-1:0]  operand_b_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [gpalu_pkg::DataW-1:0]  result_o,
  output logic                         divide_by_zero_o
);
  import gpalu_pkg::*;

  gpalu_cmd_t cmd;

  gpalu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  gpalu_dp u_dp (
    .clk_i            (clk_i),
    .cmd_i            (cmd),
    .mode_i           (mode_i),
    .operand_a_i      (operand_a_i),
    .operand_b_i      (operand_b_i),
    .result_o         (result_o),
    .divide_by_zero_o (divide_by_zero_o)
  );

endmodule

### verif/gf2_polynomial_alu_top_tb.sv
module gf2_polynomial_alu_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gpalu_pkg::*;

  localparam int RandomOps  = 1350;
  localparam int SettleWait = 80;
  localparam int CycleLimit = 600_000;

  localparam logic [DataW-1:0] AllOnes = {DataW{1'b1}};
  localparam logic [DataW-1:0] TopBit  = {1'b1, {(DataW-1){1'b0}}};
  localparam logic [DataW-1:0] PolyMask = AllOnes >> (DataW - PolyWidth);

  typedef struct {
    mode_e            mode;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    bit               drain_first;
  } poly_op_t;

  typedef struct {
    logic [DataW-1:0] result;
    logic             divide_by_zero;
  } alu_answer_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [1:0]       mode_i = MODE_ADD;
  logic [DataW-1:0] operand_a_i = '0;
  logic [DataW-1:0] operand_b_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [DataW-1:0] result_o;
  logic             divide_by_zero_o;

  poly_op_t    pending_ops[$];
  alu_answer_t awaited_answers[$];
  alu_answer_t oldest_answer;
  poly_op_t    next_op;

  int beats_sent = 0;
  int results_seen = 0;
  int send_gap = 0;
  int recv_stall = 0;
  int mismatches = 0;
  int cycle_count = 0;
  bit next_valid;

  gf2_polynomial_alu_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .operand_a_i     (operand_a_i),
    .operand_b_i     (operand_b_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_o        (result_o),
    .divide_by_zero_o(divide_by_zero_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int poly_degree(logic [DataW-1:0] p);
    int d = 0;
    for (int i = 0; i < DataW; i++) begin
      if (p[i]) d = i;
    end
    return d;
  endfunction

  function automatic logic [DataW-1:0] carryless_product(logic [DataW-1:0] a,
                                                        logic [DataW-1:0] b);
    logic [DataW-1:0] acc = '0;
    for (int i = 0; i < PolyWidth; i++) begin
      if (b[i]) acc ^= a << i;
    end
    return acc & PolyMask;
  endfunction

  function automatic void poly_divide(input logic [DataW-1:0] a, input logic [DataW-1:0] b,
                                      output logic [DataW-1:0] quo,
                                      output logic [DataW-1:0] rem);
    int da;
    int db;
    quo = '0;
    rem = a;
    if (a == '0 || b == '0) return;
    da = poly_degree(a);
    db = poly_degree(b);
    if (da < db) return;
    for (int i = da - db; i >= 0; i--) begin
      if (rem[i + db]) begin
        rem ^= b << i;
        quo[i] = 1'b1;
      end
    end
  endfunction

  function automatic alu_answer_t compute_answer(mode_e mode, logic [DataW-1:0] a_in,
                                                 logic [DataW-1:0] b_in);
    alu_answer_t ans;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] rem;
    a = a_in & PolyMask;
    b = b_in & PolyMask;
    ans.divide_by_zero = 1'b0;
    case (mode)
      MODE_ADD: begin
        ans.result = a ^ b;
      end
      MODE_MUL: begin
        ans.result = carryless_product(a, b);
      end
      default: begin
        poly_divide(a, b, quo, rem);
        ans.result = (mode == MODE_QUO) ? quo : rem;
        ans.divide_by_zero = (b == '0);
      end
    endcase
    ans.result &= PolyMask;
    return ans;
  endfunction

  // Mixes full random words, words cut to a random degree, single terms and zero.
  function automatic logic [DataW-1:0] rand_poly();
    logic [DataW-1:0] v;
    int deg;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = {{(DataW-1){1'b0}}, 1'b1} << $urandom_range(0, DataW - 1);
      2, 3, 4: begin
        deg = $urandom_range(0, DataW - 1);
        v &= ({{(DataW-2){1'b0}}, 2'b10} << deg) - 1;
      end
      5: begin
        deg = $urandom_range(0, 12);
        v &= ({{(DataW-2){1'b0}}, 2'b10} << deg) - 1;
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic int draw_wait(int count);
    // Every fourth stretch of beats runs without any idle cycles.
    if ((count / 150) % 4 == 3) return 0;
    return $urandom_range(0, 5);
  endfunction

  task automatic add_op(mode_e mode, logic [DataW-1:0] a, logic [DataW-1:0] b,
                        bit drain_first = 1'b0);
    poly_op_t op;
    op.mode = mode;
    op.a = a;
    op.b = b;
    op.drain_first = drain_first;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  // Sender: one beat in flight, a drawn gap between beats, and some beats held
  // back until every earlier result has come out.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      next_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        next_valid = 1'b0;
        beats_sent++;
        send_gap = draw_wait(beats_sent);
      end
      if (!next_valid && pending_ops.size() != 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!pending_ops[0].drain_first || beats_sent == results_seen) begin
          next_op = pending_ops.pop_front();
          mode_i <= next_op.mode;
          operand_a_i <= next_op.a;
          operand_b_i <= next_op.b;
          next_valid = 1'b1;
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // Receiver: the stall only counts down while a result is actually waiting.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        recv_stall = draw_wait(results_seen);
      end else if (out_valid_o && recv_stall > 0) begin
        recv_stall--;
      end
      out_ready_i <= (recv_stall == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen <= results_seen + 1;
        if (awaited_answers.size() == 0) begin
          $display("%0t: unexpected result beat: result %h divide_by_zero %b",
                   $time, result_o, divide_by_zero_o);
          mismatches++;
        end else begin
          oldest_answer = awaited_answers.pop_front();
          if (result_o !== oldest_answer.result) begin
            $display("%0t: result mismatch: expected %h, actual %h",
                     $time, oldest_answer.result, result_o);
            mismatches++;
          end
          if (divide_by_zero_o !== oldest_answer.divide_by_zero) begin
            $display("%0t: divide_by_zero mismatch: expected %b, actual %b",
                     $time, oldest_answer.divide_by_zero, divide_by_zero_o);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        awaited_answers.insert(awaited_answers.size(),
                               compute_answer(mode_e'(mode_i), operand_a_i, operand_b_i));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    add_op(MODE_ADD, '0, '0);
    add_op(MODE_ADD, AllOnes, AllOnes);
    add_op(MODE_ADD, AllOnes, '0);
    add_op(MODE_ADD, TopBit, 64'd1);
    add_op(MODE_MUL, AllOnes, AllOnes);
    add_op(MODE_MUL, TopBit, TopBit);
    add_op(MODE_MUL, 64'd1, AllOnes);
    add_op(MODE_MUL, 64'd3, 64'd3);
    add_op(MODE_MUL, '0, AllOnes);
    add_op(MODE_MUL, 64'h0000_0001_0000_0001, 64'h8000_0001_0000_0003);
    add_op(MODE_QUO, AllOnes, 64'd1);
    add_op(MODE_QUO, AllOnes, '0);
    add_op(MODE_QUO, '0, '0);
    add_op(MODE_QUO, '0, 64'd5);
    add_op(MODE_QUO, 64'd5, AllOnes);
    add_op(MODE_QUO, TopBit, 64'd3);
    add_op(MODE_QUO, 64'h1234_5678_9abc_def0, 64'h1234_5678_9abc_def0);
    add_op(MODE_REM, AllOnes, '0);
    add_op(MODE_REM, TopBit | 64'd1, 64'h11b);
    add_op(MODE_REM, 64'd3, TopBit);
    add_op(MODE_REM, AllOnes, AllOnes);
    add_op(MODE_REM, 64'h1234, 64'd1);
    add_op(MODE_REM, TopBit, TopBit | 64'h1b);
    // The first random beat waits for the directed results to drain.
    for (int n = 0; n < RandomOps; n++) begin
      add_op(mode_e'($urandom_range(0, 3)), rand_poly(), rand_poly(),
             (n == 0) || ($urandom_range(0, 49) == 0));
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pending_ops.size() != 0 || in_valid_i || results_seen != beats_sent);
    repeat (SettleWait) @(posedge clk_i);

    if (mismatches == 0 && awaited_answers.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/gpalu_pkg.sv
hw/rtl/gpalu_ctrl.sv
hw/rtl/gpalu_dp.sv
hw/rtl/gf2_polynomial_alu_top.sv
verif/gf2_polynomial_alu_top_tb.sv
